// File: rtl/text_console_cell_writer_unit_macros.svh
// Assertion macros shared by the console RTL
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define TCCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tccw_pkg.sv
// Package: field widths, character codes and command types of the console
`timescale 1ns / 1ps
package tccw_pkg;
	localparam int MODE_W = 2;
	localparam int CHAR_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = 16;

	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
	// spare code: no effect, cursor reported unchanged
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	localparam logic [7:0]        ATTR_RESET  = 8'd10;
	localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

	// paddr[2] selects the register word
	localparam logic REG_TEXT_ATTR = 1'b0;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_RETURN,
		OP_READ,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CHAR_W-1:0] char_code;
	} cmd_t;
endpackage

// File: rtl/tccw_ifs.sv
// Interfaces: command and response channels
`timescale 1ns / 1ps
interface tccw_in_if import tccw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [CHAR_W-1:0] char_code;
	logic [ROW_W-1:0]  cell_row;
	logic [COL_W-1:0]  cell_col;

	modport source(output valid, mode, char_code, cell_row, cell_col, input ready);
	modport sink(input valid, mode, char_code, cell_row, cell_col, output ready);
endinterface

interface tccw_out_if import tccw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_value;
	logic [ROW_W-1:0]  cursor_row;
	logic [COL_W-1:0]  cursor_col;

	modport source(output valid, cell_value, cursor_row, cursor_col, input ready);
	modport sink(input valid, cell_value, cursor_row, cursor_col, output ready);
endinterface

// File: rtl/tccw_front.sv
// Front end: takes command transfers, decodes them into back-end ops
`timescale 1ns / 1ps
module tccw_front import tccw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int AW      = 11
) (
	tccw_in_if.sink        cmd,
	input  logic           enable,
	input  logic           q_full,
	output logic           push,
	output cmd_t           push_cmd,
	output logic [AW-1:0]  push_addr
);
	logic in_range;

	assign cmd.ready = enable && !q_full;
	assign push      = cmd.valid && cmd.ready;
	assign in_range  = (32'(cmd.cell_row) < ROWS) && (32'(cmd.cell_col) < COLUMNS);
	assign push_addr = AW'(cmd.cell_row) * AW'(COLUMNS) + AW'(cmd.cell_col);

	always_comb begin
		push_cmd.char_code = cmd.char_code;
		unique case (cmd.mode)
			MODE_PUT: begin
				unique case (cmd.char_code)
					CH_NEWLINE:   push_cmd.op = OP_NEWLINE;
					CH_BACKSPACE: push_cmd.op = OP_BACKSPACE;
					CH_RETURN:    push_cmd.op = OP_RETURN;
					default:      push_cmd.op = OP_PUT;
				endcase
			end
			// out-of-range read returns zero with the cursor unchanged
			MODE_READ:  push_cmd.op = in_range ? OP_READ : OP_NOP;
			MODE_CLEAR: push_cmd.op = OP_CLEAR;
			default:    push_cmd.op = OP_NOP;
		endcase
	end
endmodule

// File: rtl/tccw_queue.sv
// Two-entry queue between front and back ends
`timescale 1ns / 1ps
`include "text_console_cell_writer_unit_macros.svh"
module tccw_queue #(
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output logic [DW-1:0] pop_data
);
	logic [DW-1:0] ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full     = count_q == 2'd2;
	assign valid    = count_q != 2'd0;
	assign pop_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`TCCW_ASSERT_NOW(a_q_count, 1'b1, count_q <= 2'd2, "queue count beyond depth")
	`TCCW_ASSERT_NEXT(a_q_fill, push && !pop && count_q == 2'd1, full, "queue did not fill")
	`TCCW_ASSERT_NOW(a_q_pop, pop, valid, "pop from empty queue")
endmodule

// File: rtl/tccw_back.sv
// Back end: screen store, cursor, scroll/clear sweeps and result register
`timescale 1ns / 1ps
`include "text_console_cell_writer_unit_macros.svh"
module tccw_back import tccw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int AW      = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    attr,
	input  logic          q_valid,
	input  cmd_t          q_cmd,
	input  logic [AW-1:0] q_addr,
	output logic          pop,
	output logic          init_busy,
	tccw_out_if.source    rsp
);
	localparam int TOTAL = ROWS * COLUMNS;
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);

	typedef enum logic [2:0] {S_INIT, S_IDLE, S_READ, S_SCROLL, S_BLANK} state_t;

	state_t              state_q;
	logic [AW-1:0]       idx_q;
	logic [RW-1:0]       row_q;
	logic [CW-1:0]       col_q;
	logic [AW-1:0]       base_q;
	logic                copy_vld_s1;
	logic [AW-1:0]       copy_addr_s1;
	logic [CELL_W-1:0]   mem_q [TOTAL];
	logic [CELL_W-1:0]   rdata_q;
	logic                out_vld_q;
	logic [CELL_W-1:0]   out_value_q;
	logic [ROW_W-1:0]    out_row_q;
	logic [COL_W-1:0]    out_col_q;

	logic                out_free;
	logic [CELL_W-1:0]   blank;
	logic                wrap;
	logic [RW-1:0]       nrow;
	logic [CW-1:0]       ncol;
	logic [AW-1:0]       nbase;
	logic                go_scroll, go_clear, go_read, done;
	logic                we;
	logic [AW-1:0]       waddr, raddr;
	logic [CELL_W-1:0]   wdata;

	assign out_free  = !out_vld_q || rsp.ready;
	assign pop       = state_q == S_IDLE && q_valid && out_free;
	assign blank     = {attr, CH_SPACE};
	assign init_busy = state_q == S_INIT;
	assign wrap      = q_cmd.op == OP_NEWLINE ||
		(q_cmd.op == OP_PUT && col_q == CW'(COLUMNS - 1));

	assign rsp.valid      = out_vld_q;
	assign rsp.cell_value = out_value_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.cursor_col = out_col_q;

	// cursor effect of one popped op
	always_comb begin
		nrow = row_q;
		ncol = col_q;
		nbase = base_q;
		go_scroll = 1'b0;
		go_clear = 1'b0;
		go_read = 1'b0;
		done = 1'b0;
		unique case (q_cmd.op)
			OP_PUT, OP_NEWLINE: begin
				if (wrap) begin
					ncol = '0;
					if (row_q == RW'(ROWS - 1)) begin
						go_scroll = 1'b1;
					end else begin
						nrow = row_q + RW'(1);
						nbase = base_q + AW'(COLUMNS);
						done = 1'b1;
					end
				end else begin
					ncol = col_q + CW'(1);
					done = 1'b1;
				end
			end
			OP_BACKSPACE: begin
				if (col_q != '0) ncol = col_q - CW'(1);
				done = 1'b1;
			end
			OP_RETURN: begin
				ncol = '0;
				done = 1'b1;
			end
			OP_READ: go_read = 1'b1;
			OP_CLEAR: begin
				nrow = '0;
				ncol = '0;
				nbase = '0;
				go_clear = 1'b1;
			end
			default: done = 1'b1;
		endcase
	end

	// one write port: copy drain first, then sweeps, then cursor writes
	always_comb begin
		we = 1'b0;
		waddr = copy_addr_s1;
		wdata = rdata_q;
		if (copy_vld_s1) begin
			we = 1'b1;
		end else if (state_q == S_INIT) begin
			we = 1'b1;
			waddr = idx_q;
			wdata = BLANK_RESET;
		end else if (state_q == S_BLANK) begin
			we = 1'b1;
			waddr = idx_q;
			wdata = blank;
		end else if (pop && q_cmd.op == OP_PUT) begin
			we = 1'b1;
			waddr = base_q + AW'(col_q);
			wdata = {attr, q_cmd.char_code};
		end else if (pop && q_cmd.op == OP_BACKSPACE && col_q != '0) begin
			we = 1'b1;
			waddr = base_q + AW'(col_q) - AW'(1);
			wdata = blank;
		end
	end

	assign raddr = (state_q == S_SCROLL) ? idx_q : q_addr;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			idx_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			base_q       <= '0;
			copy_vld_s1  <= 1'b0;
			copy_addr_s1 <= '0;
			out_vld_q    <= 1'b0;
			out_value_q  <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
		end else begin
			// an op that completes on pop reloads the result register in the same cycle
			if (out_vld_q && rsp.ready && !(pop && done)) out_vld_q <= 1'b0;
			copy_vld_s1  <= state_q == S_SCROLL;
			copy_addr_s1 <= idx_q - AW'(COLUMNS);
			unique case (state_q)
				S_INIT: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == AW'(TOTAL - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (pop) begin
						row_q  <= nrow;
						col_q  <= ncol;
						base_q <= nbase;
						if (done) begin
							out_vld_q   <= 1'b1;
							out_value_q <= '0;
							out_row_q   <= ROW_W'(nrow);
							out_col_q   <= COL_W'(ncol);
						end
						if (go_read) state_q <= S_READ;
						if (go_scroll) begin
							idx_q   <= AW'(COLUMNS);
							state_q <= S_SCROLL;
						end
						if (go_clear) begin
							idx_q   <= '0;
							state_q <= S_BLANK;
						end
					end
				end
				S_READ: begin
					out_vld_q   <= 1'b1;
					out_value_q <= rdata_q;
					out_row_q   <= ROW_W'(row_q);
					out_col_q   <= COL_W'(col_q);
					state_q     <= S_IDLE;
				end
				S_SCROLL: begin
					if (idx_q == AW'(TOTAL - 1)) begin
						idx_q   <= AW'(TOTAL - COLUMNS);
						state_q <= S_BLANK;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_BLANK: begin
					// wait out the last copy write before blanking
					if (!copy_vld_s1) begin
						if (idx_q == AW'(TOTAL - 1)) begin
							out_vld_q   <= 1'b1;
							out_value_q <= '0;
							out_row_q   <= ROW_W'(row_q);
							out_col_q   <= COL_W'(col_q);
							state_q     <= S_IDLE;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TCCW_ASSERT_NOW(a_cursor_range, 1'b1,
		(32'(row_q) < ROWS) && (32'(col_q) < COLUMNS), "cursor off screen")
	`TCCW_ASSERT_NOW(a_read_slot, state_q == S_READ, !out_vld_q,
		"result register busy during read")
	`TCCW_ASSERT_NOW(a_copy_state, copy_vld_s1,
		state_q == S_SCROLL || state_q == S_BLANK, "copy write outside scroll")
	`TCCW_ASSERT_NEXT(a_read_next, pop && q_cmd.op == OP_READ, state_q == S_READ,
		"read op did not enter read state")
endmodule

// File: rtl/text_console_cell_writer_unit.sv
// Top level: text console engine with APB attribute register
`timescale 1ns / 1ps
// Text console engine. A put, return, backspace or non-scrolling newline is
// done in the back end as it is popped; a read passes through a read state
// for the registered store read. A line feed or wrap past the last row
// scrolls: the store, which has one write port, is copied one cell a cycle
// and the new bottom row blanked. A clear blanks every cell. After reset a
// clearing pass fills the store with blanks; no command is accepted until it
// ends, while attribute writes are taken. A two entry command queue lets the
// front keep taking transfers while the back end works or a result waits.
// The attribute register sits at byte address 0.
module text_console_cell_writer_unit import tccw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	tccw_in_if.sink     cmd,
	tccw_out_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = $clog2(ROWS * COLUMNS);
	localparam int DW = AW + $bits(cmd_t);

	logic [7:0]    attr_q;
	logic          q_full, push, pop, q_valid, init_busy;
	cmd_t          push_cmd, q_cmd;
	logic [AW-1:0] push_addr, q_addr;
	logic [DW-1:0] q_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'd0, attr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_ATTR) begin
			attr_q <= pwdata[7:0];
		end
	end

	tccw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS), .AW(AW)) u_front (
		.cmd       (cmd),
		.enable    (!init_busy),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_addr (push_addr)
	);

	tccw_queue #(.DW(DW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_addr, push_cmd}),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	assign q_addr = q_data[DW-1 -: AW];
	assign q_cmd  = cmd_t'(q_data[$bits(cmd_t)-1:0]);

	tccw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .AW(AW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.attr      (attr_q),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_addr    (q_addr),
		.pop       (pop),
		.init_busy (init_busy),
		.rsp       (rsp)
	);
endmodule
